>>> rtl/sha_pkg.sv
package sha_pkg;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        final_word;
    } digest_item_t;

    typedef struct packed {
        logic       shift;
        logic       step;
        logic [7:0] data;
    } sched_ctl_t;

    typedef struct packed {
        logic init;
        logic step;
        logic finish;
        logic restart;
    } round_ctl_t;

    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [5:0] LAST_BYTE  = 6'd63;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    localparam word_t SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

endpackage

>>> rtl/sha_sched.sv
module sha_sched (
    input  logic                clk,
    input  sha_pkg::sched_ctl_t ctl,
    output sha_pkg::word_t      w
);
    import sha_pkg::*;

    // 16-word window; bytes shift in at the bottom, word 0 sits at the top
    logic [511:0] win_reg;
    word_t        new_w;

    assign w = win_reg[511:480];

    always_comb
    begin
        new_w = win_reg[511:480] + small_sigma0(win_reg[479:448])
              + win_reg[223:192] + small_sigma1(win_reg[63:32]);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            win_reg <= {win_reg[503:0], ctl.data};
        end
        else if (ctl.step)
        begin
            win_reg <= {win_reg[479:0], new_w};
        end
    end

endmodule

>>> rtl/sha_round.sv
module sha_round (
    input  logic                clk,
    input  logic                rst_n,
    input  sha_pkg::round_ctl_t ctl,
    input  logic [5:0]          rnd,
    input  sha_pkg::word_t      w,
    output sha_pkg::word_t      chain [8]
);
    import sha_pkg::*;

    word_t chain_reg [8];
    word_t work_reg [8];
    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;

    assign chain = chain_reg;

    always_comb
    begin
        ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
            ^ (work_reg[1] & work_reg[2]);
        t1  = work_reg[7] + big_sigma1(work_reg[4]) + ch + SHA_K[rnd] + w;
        t2  = big_sigma0(work_reg[0]) + maj;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.init)
        begin
            work_reg <= chain_reg;
        end
        else if (ctl.step)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= SHA_IV;
        end
        else if (ctl.restart)
        begin
            chain_reg <= SHA_IV;
        end
        else if (ctl.finish)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= chain_reg[i] + work_reg[i];
            end
        end
    end

endmodule

>>> rtl/sha256_stream_hash.sv
// Byte items are taken one per cycle while idle, until a 64-byte block fills; the input
// then stalls while the shared round unit runs the 64 rounds and then the chain add.
// A closing item adds one pad byte per cycle up to the block end (one or two blocks, each
// followed by the compression), then eight digest words are offered one per cycle while
// digest_stall is low, most significant first.
// Reset (async, active low) loads the initial hash vector and clears the byte count.
module sha256_stream_hash (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  msg_valid,
    output logic                  msg_stall,
    input  sha_pkg::msg_item_t    msg,
    output logic                  digest_valid,
    input  logic                  digest_stall,
    output sha_pkg::digest_item_t digest
);
    import sha_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_COMP = 3'd1;
    localparam logic [2:0] ST_FIN  = 3'd2;
    localparam logic [2:0] ST_PAD  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [60:0] seen_reg, seen_next;
    logic [63:0] len_reg, len_next;
    logic        close_reg, close_next;
    logic        first_reg, first_next;
    logic        len_blk_reg, len_blk_next;
    logic        done_reg, done_next;
    logic [2:0]  word_reg, word_next;

    sched_ctl_t  sc;
    round_ctl_t  rc;
    word_t       w;
    word_t       chain [8];

    sha_sched u_sched (
        .clk (clk),
        .ctl (sc),
        .w   (w)
    );

    sha_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rc),
        .rnd   (rnd_reg),
        .w     (w),
        .chain (chain)
    );

    assign msg_stall           = (state_reg != ST_IDLE);
    assign digest_valid        = (state_reg == ST_OUT);
    assign digest.digest_word  = chain[word_reg];
    assign digest.word_number  = word_reg;
    assign digest.final_word   = (word_reg == LAST_WORD);

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        rnd_next     = rnd_reg;
        seen_next    = seen_reg;
        len_next     = len_reg;
        close_next   = close_reg;
        first_next   = first_reg;
        len_blk_next = len_blk_reg;
        done_next    = done_reg;
        word_next    = word_reg;
        sc           = '0;
        rc           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    if (msg.byte_present)
                    begin
                        sc.shift  = 1'b1;
                        sc.data   = msg.data_byte;
                        fill_next = fill_reg + 6'd1;
                        seen_next = seen_reg + 61'd1;
                    end
                    if (msg.end_of_message)
                    begin
                        len_next   = {seen_next, 3'b000};
                        seen_next  = '0;
                        close_next = 1'b1;
                        first_next = 1'b1;
                        done_next  = 1'b0;
                    end
                    if (msg.byte_present && fill_reg == LAST_BYTE)
                    begin
                        rc.init    = 1'b1;
                        rnd_next   = '0;
                        state_next = ST_COMP;
                    end
                    else if (msg.end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_COMP:
            begin
                rc.step  = 1'b1;
                sc.step  = 1'b1;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                rc.finish = 1'b1;
                if (done_reg)
                begin
                    word_next  = '0;
                    state_next = ST_OUT;
                end
                else if (close_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                sc.shift  = 1'b1;
                fill_next = fill_reg + 6'd1;
                if (first_reg)
                begin
                    sc.data      = PAD_BYTE;
                    first_next   = 1'b0;
                    len_blk_next = (fill_reg < LEN_POS);
                end
                else if (len_blk_reg && fill_reg >= LEN_POS)
                begin
                    sc.data  = len_reg[63:56];
                    len_next = {len_reg[55:0], 8'h00};
                end
                else
                begin
                    sc.data = 8'h00;
                end
                if (fill_reg == LAST_BYTE)
                begin
                    done_next    = !first_reg && len_blk_reg;
                    len_blk_next = 1'b1;
                    rc.init      = 1'b1;
                    rnd_next     = '0;
                    state_next   = ST_COMP;
                end
            end
            ST_OUT:
            begin
                if (!digest_stall)
                begin
                    if (word_reg == LAST_WORD)
                    begin
                        rc.restart = 1'b1;
                        close_next = 1'b0;
                        done_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        word_next = word_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            rnd_reg     <= '0;
            seen_reg    <= '0;
            close_reg   <= 1'b0;
            first_reg   <= 1'b0;
            len_blk_reg <= 1'b0;
            done_reg    <= 1'b0;
            word_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            rnd_reg     <= rnd_next;
            seen_reg    <= seen_next;
            close_reg   <= close_next;
            first_reg   <= first_next;
            len_blk_reg <= len_blk_next;
            done_reg    <= done_next;
            word_reg    <= word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

endmodule
